// ===== rtl/dtzs_pkg.sv =====
// Shared types, constants and state encoding for the decimal trailing-zero strip block.
package dtzs_pkg;

  // Coefficient geometry.
  localparam int unsigned CoefW     = 96;
  localparam int unsigned LowW      = 64;
  localparam int unsigned HighW     = 32;
  localparam int unsigned ScaleW    = 5;

  // The long division by ten walks the coefficient in chunks, most significant first.
  localparam int unsigned ChunkW    = 24;
  localparam int unsigned NumChunks = CoefW / ChunkW;
  localparam int unsigned ChunkIdxW = $clog2(NumChunks);
  localparam int unsigned RemW      = 4;
  localparam int unsigned DivInW    = RemW + ChunkW;
  localparam int unsigned ProdW     = 2 * DivInW;

  // floor(x / 10) = (x * RecipTen) >> RecipShift for every x below 2^30.
  localparam int unsigned RecipShift = 31;
  localparam logic [DivInW-1:0] RecipTen = DivInW'(214748365);

  localparam logic [ChunkIdxW-1:0] LastChunk = ChunkIdxW'(NumChunks - 1);

  typedef struct packed {
    logic [LowW-1:0]   coef_low;
    logic [HighW-1:0]  coef_high;
    logic [ScaleW-1:0] scale_in;
    logic              sign_in;
  } in_item_t;

  typedef struct packed {
    logic [LowW-1:0]   coef_low_out;
    logic [HighW-1:0]  coef_high_out;
    logic [ScaleW-1:0] scale_out;
    logic              sign_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new input item
    logic start_div;  // clear the remainder and chunk index
    logic step;       // divide one chunk
    logic commit;     // take the quotient, lower the scale
    logic emit;       // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scale_zero;
    logic last_chunk;
    logic rem_zero;
    logic out_free;
  } dpath_stat_t;

endpackage

// ===== rtl/dtzs_ctrl.sv =====
// Controller state machine that sequences the divide-by-ten passes.
module dtzs_ctrl import dtzs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  dpath_stat_t stat_i,
  output ctrl_cmd_t   cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = stat_i.scale_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.last_chunk) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = stat_i.rem_zero ? ST_CHECK : ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.start_div = !stat_i.scale_zero;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
      end
      ST_EVAL: begin
        cmd_o.commit = stat_i.rem_zero;
      end
      ST_DONE: begin
        cmd_o.emit = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/dtzs_dpath.sv =====
// Datapath: coefficient registers, chunked divide-by-ten unit and output register.
module dtzs_dpath import dtzs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  ctrl_cmd_t   cmd_i,
  output dpath_stat_t stat_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output out_item_t   out_item_o
);

  logic [CoefW-1:0]     coef_q, coef_d;
  logic [CoefW-1:0]     quot_q, quot_d;
  logic [ScaleW-1:0]    scale_q, scale_d;
  logic                 sign_q, sign_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [ChunkIdxW-1:0] idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;

  logic [ChunkIdxW-1:0] sel;
  logic [ChunkW-1:0]    chunk;
  logic [DivInW-1:0]    div_in;
  logic [ProdW-1:0]     prod;
  logic [ChunkW-1:0]    quot_chunk;
  logic [DivInW-1:0]    quot_times_ten;
  logic [DivInW-1:0]    div_diff;

  // Chunks are taken from the top of the coefficient downward.
  assign sel   = ~idx_q;
  assign chunk = coef_q[sel*ChunkW +: ChunkW];

  // One step of long division: (remainder, chunk) divided by ten via a reciprocal multiply.
  assign div_in         = {rem_q, chunk};
  assign prod           = ProdW'(div_in) * ProdW'(RecipTen);
  assign quot_chunk     = prod[RecipShift +: ChunkW];
  assign quot_times_ten = (DivInW'(quot_chunk) << 3) + (DivInW'(quot_chunk) << 1);
  assign div_diff       = div_in - quot_times_ten;

  // Working registers.
  always_comb begin
    coef_d  = coef_q;
    quot_d  = quot_q;
    scale_d = scale_q;
    sign_d  = sign_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    if (cmd_i.load) begin
      coef_d  = {in_item_i.coef_high, in_item_i.coef_low};
      scale_d = in_item_i.scale_in;
      sign_d  = in_item_i.sign_in;
    end
    if (cmd_i.start_div) begin
      rem_d = '0;
      idx_d = '0;
    end
    if (cmd_i.step) begin
      quot_d[sel*ChunkW +: ChunkW] = quot_chunk;
      rem_d = div_diff[RemW-1:0];
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.commit) begin
      coef_d  = quot_q;
      scale_d = scale_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q  <= coef_d;
    quot_q  <= quot_d;
    scale_q <= scale_d;
    sign_q  <= sign_d;
  end

  // Output register: a finished item waits here while the next one is worked on.
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d              = 1'b1;
      out_item_d.coef_low_out  = coef_q[LowW-1:0];
      out_item_d.coef_high_out = coef_q[CoefW-1:LowW];
      out_item_d.scale_out     = scale_q;
      out_item_d.sign_out      = sign_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  // Status back to the controller.
  assign stat_o.scale_zero = (scale_q == '0);
  assign stat_o.last_chunk = (idx_q == LastChunk);
  assign stat_o.rem_zero   = (rem_q == '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/decimal_trailing_zero_strip.sv =====
// Top level of the decimal trailing-zero strip block.
// The input channel (in_valid_i, in_ready_o, in_item_i) takes a 96-bit unsigned
// coefficient, a 5-bit scale and a sign. The output channel (out_valid_o,
// out_ready_i, out_item_o) returns one item per input: the coefficient with
// trailing decimal zeros removed while the scale is above zero, the lowered
// scale and the unchanged sign. A zero coefficient leaves with scale zero.
// Items are processed one at a time. Each trial division by ten walks the
// coefficient in four 24-bit chunks through one reciprocal multiplier, so a
// pass runs through a check, four chunk steps and an evaluate step. At most
// 31 digits are removed from one item. The input is ready again from the
// clock edge at which the result enters the output register, so a new item is
// worked on while the result still waits there. If the receiver stalls with a
// result already held, the next result waits in the datapath and the input
// stays closed.
// Reset is asynchronous and active low; it empties the output register and
// returns the controller to idle.
module decimal_trailing_zero_strip import dtzs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t   cmd;
  dpath_stat_t stat;

  // Sequencer.
  dtzs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  dtzs_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the decimal trailing-zero strip block.
module tb import dtzs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainCycles = 220;
  localparam int unsigned MaxPrinted  = 20;
  localparam int unsigned MaxZeros    = 28;
  localparam int unsigned HoldCycles  = 400;
  localparam logic [CoefW-1:0] Ten     = CoefW'(10);
  localparam logic [CoefW-1:0] AllOnes = '1;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Expected results, oldest first.
  out_item_t stripped_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned max_strip = 0;
  int unsigned zero_coef_items = 0;
  int unsigned deep_strip_items = 0;

  decimal_trailing_zero_strip i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Power of ten as a 96-bit value.
  function automatic logic [CoefW-1:0] pow10(int unsigned exp10);
    logic [CoefW-1:0] acc;
    acc = CoefW'(1);
    for (int unsigned i = 0; i < exp10; i++) begin
      acc = acc * Ten;
    end
    return acc;
  endfunction

  // Expected result: divide by ten while the scale allows and the remainder is zero.
  function automatic out_item_t strip_zeros(in_item_t item);
    logic [CoefW-1:0]  coef;
    logic [ScaleW-1:0] scale;
    out_item_t         res;
    coef  = {item.coef_high, item.coef_low};
    scale = item.scale_in;
    while (scale != '0 && (coef % Ten) == '0) begin
      coef  = coef / Ten;
      scale = scale - 1'b1;
    end
    res.coef_low_out  = coef[LowW-1:0];
    res.coef_high_out = coef[CoefW-1:LowW];
    res.scale_out     = scale;
    res.sign_out      = item.sign_in;
    return res;
  endfunction

  function automatic in_item_t make_item(logic [CoefW-1:0] coef, int unsigned scale,
                                         logic sign);
    in_item_t item;
    item.coef_low  = coef[LowW-1:0];
    item.coef_high = coef[CoefW-1:LowW];
    item.scale_in  = ScaleW'(scale);
    item.sign_in   = sign;
    return item;
  endfunction

  // Random item: mostly a mantissa times a power of ten, plus raw values and bit patterns.
  function automatic in_item_t random_item();
    logic [CoefW-1:0] coef;
    logic [CoefW-1:0] base;
    logic [CoefW-1:0] room;
    int unsigned      pick;
    int unsigned      zeros;
    int unsigned      scale;
    int unsigned      bit_pos;
    pick  = $urandom_range(99);
    zeros = $urandom_range(MaxZeros);
    room  = AllOnes / pow10(zeros);
    base  = {$urandom, $urandom, $urandom};
    bit_pos = $urandom_range(CoefW - 1);
    if (pick < 62) begin
      if ($urandom_range(3) == 0) begin
        base = base % CoefW'(1000);
      end
      coef = (base % room) * pow10(zeros);
    end else if (pick < 77) begin
      coef = base;
    end else if (pick < 85) begin
      coef = ($urandom_range(1) == 0) ? '0 : CoefW'($urandom_range(9)) * pow10(zeros);
    end else begin
      case ($urandom_range(4))
        0: coef = {{HighW{1'b1}}, {LowW{1'b0}}};
        1: coef = {{HighW{1'b0}}, {LowW{1'b1}}};
        2: coef = CoefW'(1) << bit_pos;
        3: coef = ~(CoefW'(1) << bit_pos);
        default: coef = AllOnes;
      endcase
    end
    // Half the scales are uniform, half sit at or just above the number of zeros.
    if ($urandom_range(1) == 0) begin
      scale = $urandom_range(31);
    end else begin
      scale = zeros + $urandom_range(3);
      if (scale > 31) begin
        scale = 31;
      end
    end
    return make_item(coef, scale, 1'($urandom_range(1)));
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Offer one item and wait until it is accepted; valid drops on the next falling edge.
  task automatic send_item(in_item_t item);
    out_item_t   want;
    int unsigned strips;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    want = strip_zeros(item);
    stripped_q.push_back(want);
    items_sent++;
    strips = int'(item.scale_in) - int'(want.scale_out);
    if (strips > max_strip) begin
      max_strip = strips;
    end
    if (strips >= 20) begin
      deep_strip_items++;
    end
    if ({item.coef_high, item.coef_low} == '0) begin
      zero_coef_items++;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_random_items(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_item(random_item());
    end
  endtask

  // Extremes of the fields and each special case.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // A zero coefficient is stripped down to scale zero.
    send_item(make_item('0, 0, 1'b0));
    send_item(make_item('0, 31, 1'b1));
    send_item(make_item('0, 5, 1'b1));
    // Scale zero leaves trailing zeros in place.
    send_item(make_item(CoefW'(100), 0, 1'b0));
    send_item(make_item(pow10(MaxZeros), 0, 1'b1));
    // Largest coefficient and largest scale.
    send_item(make_item(AllOnes, 31, 1'b1));
    send_item(make_item(AllOnes, 0, 1'b0));
    // Scales above 28 are reduced by the same rule.
    send_item(make_item(pow10(MaxZeros), 28, 1'b0));
    send_item(make_item(pow10(MaxZeros), 29, 1'b1));
    send_item(make_item(pow10(MaxZeros), 31, 1'b0));
    send_item(make_item(CoefW'(7) * pow10(MaxZeros), 31, 1'b1));
    send_item(make_item(CoefW'(79) * pow10(27), 31, 1'b0));
    // Small values and a nonzero digit that stops the strip.
    send_item(make_item(CoefW'(1), 31, 1'b0));
    send_item(make_item(CoefW'(10), 1, 1'b0));
    send_item(make_item(CoefW'(10), 31, 1'b1));
    send_item(make_item(CoefW'(120), 1, 1'b0));
    send_item(make_item(CoefW'(1200), 1, 1'b1));
    // Values that straddle the boundary between the low and high parts.
    send_item(make_item(CoefW'(1) << LowW, 31, 1'b0));
    send_item(make_item(pow10(20), 20, 1'b1));
    send_item(make_item({{HighW{1'b0}}, {LowW{1'b1}}}, 31, 1'b0));
    send_item(make_item({{HighW{1'b1}}, {LowW{1'b0}}}, 31, 1'b1));
  endtask

  task automatic test_slow_receiver(int unsigned count);
    send_idle_pct = 15;
    recv_idle_pct = 75;
    send_random_items(count);
  endtask

  task automatic test_slow_sender(int unsigned count);
    send_idle_pct = 75;
    recv_idle_pct = 15;
    send_random_items(count);
  endtask

  task automatic test_full_rate(int unsigned count);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_items(count);
  endtask

  // The receiver holds off while items keep coming, so the block fills and closes its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_len = HoldCycles;
    hold_seq++;
    for (int unsigned i = 0; i < 6; i++) begin
      send_item(make_item({$urandom, $urandom, $urandom}, 0, 1'($urandom_range(1))));
    end
    send_random_items(6);
  endtask

  task automatic wait_for_drain();
    while (stripped_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Output ready: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (stripped_q.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        want = stripped_q.pop_front();
        results_checked++;
        if (out_item_o.coef_low_out !== want.coef_low_out) begin
          report_mismatch($sformatf("coef_low_out got %h want %h",
                                    out_item_o.coef_low_out, want.coef_low_out));
        end
        if (out_item_o.coef_high_out !== want.coef_high_out) begin
          report_mismatch($sformatf("coef_high_out got %h want %h",
                                    out_item_o.coef_high_out, want.coef_high_out));
        end
        if (out_item_o.scale_out !== want.scale_out) begin
          report_mismatch($sformatf("scale_out got %0d want %0d",
                                    out_item_o.scale_out, want.scale_out));
        end
        if (out_item_o.sign_out !== want.sign_out) begin
          report_mismatch($sformatf("sign_out got %b want %b",
                                    out_item_o.sign_out, want.sign_out));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending",
               cycle_count, stripped_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_slow_receiver(480);
    test_slow_sender(480);
    test_full_rate(470);
    test_output_backpressure();
    wait_for_drain();

    $display("Checked %0d results for %0d items: %0d zero coefficients, %0d items with 20+",
             results_checked, items_sent, zero_coef_items, deep_strip_items);
    $display("digits stripped (most %0d), and a %0d-cycle output hold-off; %0d mismatches.",
             max_strip, HoldCycles, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dtzs_pkg.sv
rtl/dtzs_ctrl.sv
rtl/dtzs_dpath.sv
rtl/decimal_trailing_zero_strip.sv
bench/tb.sv
